[hdl/b64se_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_pkg
// Shared types and constants of the base64 stream encoder: the group record
// passed from the byte front end to the character back end, and the sextet
// to character mapping.
// ----------------------------------------------------------------------------
package b64se_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CHAR_W   = 7;
	localparam int unsigned SEXTET_W = 6;

	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3d;

	localparam logic [SEXTET_W-1:0] UPPER_END = 6'd26;
	localparam logic [SEXTET_W-1:0] LOWER_END = 6'd52;
	localparam logic [SEXTET_W-1:0] DIGIT_END = 6'd62;
	localparam logic [SEXTET_W-1:0] PLUS_IDX  = 6'd62;

	localparam logic [CHAR_W-1:0] UPPER_BASE = 7'h41;
	localparam logic [CHAR_W-1:0] LOWER_BASE = 7'h61 - 7'd26;
	localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'h30 - 7'd52;
	localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'h2b;
	localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'h2f;

	// number of pad characters closing a group
	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_ONE  = 2'd1,
		PAD_TWO  = 2'd2
	} b64se_pad_t;

	typedef struct packed {
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		b64se_pad_t        pad;
		logic              last;
	} b64se_group_t;

	typedef struct packed {
		logic push;
		logic pop;
	} b64se_qctl_t;

	function automatic logic [CHAR_W-1:0] b64se_char(input logic [SEXTET_W-1:0] v);
		logic [CHAR_W-1:0] c;
		logic [CHAR_W-1:0] v7;
		v7 = {1'b0, v};
		if (v < UPPER_END) begin
			c = UPPER_BASE + v7;
		end else if (v < LOWER_END) begin
			c = LOWER_BASE + v7;
		end else if (v < DIGIT_END) begin
			c = DIGIT_BASE + v7;
		end else if (v == PLUS_IDX) begin
			c = PLUS_CHAR;
		end else begin
			c = SLASH_CHAR;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hdl/b64se_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_front
// Byte front end: takes one byte per request, holds up to two bytes of the
// open group and hands a closed group, zero filled and with its pad count,
// to the group queue.
// ----------------------------------------------------------------------------
module b64se_front
	import b64se_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output      logic              byte_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last_byte,
	input  wire logic              q_full,
	output      logic              q_push,
	output      b64se_group_t      q_data
);

	logic [BYTE_W-1:0] pend0_q;
	logic [BYTE_W-1:0] pend1_q;
	logic [1:0]        pend_cnt_q;
	logic              accept;
	logic              hold;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;
	assign hold       = (pend_cnt_q != 2'd2) && !last_byte;
	assign q_push     = accept && !hold;

	always_comb begin
		q_data.last = last_byte;
		case (pend_cnt_q)
			2'd2: begin
				q_data.b0  = pend0_q;
				q_data.b1  = pend1_q;
				q_data.b2  = data_byte;
				q_data.pad = PAD_NONE;
			end
			2'd1: begin
				q_data.b0  = pend0_q;
				q_data.b1  = data_byte;
				q_data.b2  = '0;
				q_data.pad = PAD_ONE;
			end
			default: begin
				q_data.b0  = data_byte;
				q_data.b1  = '0;
				q_data.b2  = '0;
				q_data.pad = PAD_TWO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
		end else if (accept) begin
			if (hold) begin
				pend_cnt_q <= pend_cnt_q + 2'd1;
			end else begin
				pend_cnt_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold) begin
			if (pend_cnt_q[0]) begin
				pend1_q <= data_byte;
			end else begin
				pend0_q <= data_byte;
			end
		end
	end

	// never more than two bytes held
	a_pend_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd3)
		else $error("front holds more than two bytes");

endmodule
`default_nettype wire

[hdl/b64se_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_queue
// Short first-in first-out queue of closed groups between the byte front
// end and the character back end.
// ----------------------------------------------------------------------------
module b64se_queue
	import b64se_pkg::*;
#(
	parameter int unsigned DEPTH = 2
)
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire b64se_qctl_t  ctl,
	input  wire b64se_group_t wr_data,
	output      b64se_group_t rd_data,
	output      logic         full,
	output      logic         empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	b64se_group_t     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (ctl.push && !ctl.pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (ctl.pop && !ctl.push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !full)
		else $error("group pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !empty)
		else $error("group popped from empty queue");

endmodule
`default_nettype wire

[hdl/b64se_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_back
// Character back end: walks the head group of the queue one character
// per cycle, unless stalled, into the output register, with padding and
// the last mark, and releases the group after its fourth character.
// ----------------------------------------------------------------------------
module b64se_back
	import b64se_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire b64se_group_t      q_data,
	input  wire logic              q_empty,
	output      logic              q_pop,
	output      logic              char_valid,
	input  wire logic              char_stall,
	output      logic [CHAR_W-1:0] char_code,
	output      logic              last_char
);

	logic [1:0]          idx_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   code_q;
	logic                last_q;
	logic                load;
	logic [SEXTET_W-1:0] sextet;
	logic                is_pad;
	logic [CHAR_W-1:0]   code_nxt;

	assign load  = !q_empty && (!out_valid_q || !char_stall);
	assign q_pop = load && (idx_q == 2'd3);

	always_comb begin
		case (idx_q)
			2'd0:    sextet = q_data.b0[7:2];
			2'd1:    sextet = {q_data.b0[1:0], q_data.b1[7:4]};
			2'd2:    sextet = {q_data.b1[3:0], q_data.b2[7:6]};
			default: sextet = q_data.b2[5:0];
		endcase
		is_pad   = ((q_data.pad == PAD_TWO) && idx_q[1])
		        || ((q_data.pad == PAD_ONE) && (idx_q == 2'd3));
		code_nxt = is_pad ? PAD_CHAR : b64se_char(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (!char_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code_nxt;
			last_q <= (idx_q == 2'd3) && q_data.last;
		end
	end

	assign char_valid = out_valid_q;
	assign char_code  = code_q;
	assign last_char  = last_q;

	// a group part way through stays at the queue head
	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !q_empty)
		else $error("group left queue before its fourth character");

endmodule
`default_nettype wire

[hdl/base64_stream_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// One message byte per request on the byte channel, last_byte on the final
// byte; characters leave one per request on the char channel, last_char on
// the final one. Every three bytes give four characters, and a last byte
// closing one or two bytes gives a padded group of four. The character
// channel carries one character per cycle while char_stall is low, so the
// sustained input rate is set by the character output register. With the
// group queue empty, a closing byte's group is written into the queue and its
// first character is then loaded into the output register. Bytes are taken
// every cycle while the group queue (QUEUE_DEPTH groups) has room, so short
// bursts run at full rate.
// ----------------------------------------------------------------------------
module base64_stream_encoder
	import b64se_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
)
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output      logic              byte_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last_byte,
	output      logic              char_valid,
	input  wire logic              char_stall,
	output      logic [CHAR_W-1:0] char_code,
	output      logic              last_char
);

	b64se_qctl_t  qctl;
	logic         q_push;
	logic         q_pop;
	b64se_group_t wr_group;
	b64se_group_t head_group;
	logic         q_full;
	logic         q_empty;

	assign qctl = '{push: q_push, pop: q_pop};

	b64se_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (wr_group)
	);

	b64se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (qctl),
		.wr_data (wr_group),
		.rd_data (head_group),
		.full    (q_full),
		.empty   (q_empty)
	);

	b64se_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (head_group),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.last_char  (last_char)
	);

endmodule
`default_nettype wire

[tb/base64_encoding_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_encoding_check
// Watches the byte and character channels of the base64 stream encoder,
// works out the characters due for every byte request taken and compares
// each character request against the oldest one due.
// ----------------------------------------------------------------------------
module base64_encoding_check
	import b64se_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              byte_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	input  logic              char_valid,
	input  logic              char_stall,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              last_char,
	output int unsigned       error_count,
	output int unsigned       chars_due
);

	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} enc_char_t;

	enc_char_t         expected_chars [$];
	logic [BYTE_W-1:0] open_group [2];
	logic [1:0]        open_count;

	initial begin
		error_count   = 0;
		chars_due     = 0;
		open_group[0] = '0;
		open_group[1] = '0;
		open_count    = '0;
	end

	function automatic logic [CHAR_W-1:0] sextet_ascii(input logic [5:0] s);
		int idx;
		logic [7:0] a;
		idx = 63 - int'(s);
		a = B64_ALPHABET[8*idx +: 8];
		return a[CHAR_W-1:0];
	endfunction

	task automatic push_char(input logic [CHAR_W-1:0] code, input logic fin);
		enc_char_t c;
		c.code = code;
		c.last = fin;
		expected_chars.push_back(c);
	endtask

	task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic [23:0] grp;
		if (open_count < 2'd2 && !fin) begin
			open_group[open_count[0]] = b;
			open_count = open_count + 2'd1;
		end else begin
			case (open_count)
				2'd2: grp = {open_group[0], open_group[1], b};
				2'd1: grp = {open_group[0], b, 8'h00};
				default: grp = {b, 16'h0000};
			endcase
			push_char(sextet_ascii(grp[23:18]), 1'b0);
			push_char(sextet_ascii(grp[17:12]), 1'b0);
			case (open_count)
				2'd2: begin
					push_char(sextet_ascii(grp[11:6]), 1'b0);
					push_char(sextet_ascii(grp[5:0]), fin);
				end
				2'd1: begin
					push_char(sextet_ascii(grp[11:6]), 1'b0);
					push_char(PAD_CHAR, 1'b1);
				end
				default: begin
					push_char(PAD_CHAR, 1'b0);
					push_char(PAD_CHAR, 1'b1);
				end
			endcase
			open_group[0] = '0;
			open_group[1] = '0;
			open_count    = '0;
		end
	endtask

	task automatic check_char(input logic [CHAR_W-1:0] code, input logic fin);
		enc_char_t want;
		if (expected_chars.size() == 0) begin
			$error("char request with none due: char_code %h last_char %b", code, fin);
			error_count++;
		end else begin
			want = expected_chars.pop_front();
			if (code !== want.code) begin
				$error("char_code: expected %h, actual %h", want.code, code);
				error_count++;
			end
			if (fin !== want.last) begin
				$error("last_char: expected %b, actual %b", want.last, fin);
				error_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				check_char(char_code, last_char);
			end
			if (byte_valid && !byte_stall) begin
				encode_byte(data_byte, last_byte);
			end
			chars_due = expected_chars.size();
		end
	end

endmodule

[tb/tb_base64_stream_encoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Drives messages of random length and content into the base64 stream
// encoder after a directed set of edge cases, with random gaps on the byte
// side and random stalls on the character side, and one long hold-off that
// backs the encoder up into its input. Checking is done beside the block.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
	import b64se_pkg::*;

	localparam int unsigned RANDOM_BYTES = 200;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_AT_CHAR = 60;
	localparam int unsigned LONG_HOLD    = 200;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              byte_valid;
	logic              byte_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;
	logic              char_valid;
	logic              char_stall;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	int unsigned error_count;
	int unsigned chars_due;
	int unsigned cycle_count = 0;
	int unsigned chars_taken;

	always #5 clk = ~clk;

	base64_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.last_char  (last_char)
	);

	base64_encoding_check encoding_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.last_char   (last_char),
		.error_count (error_count),
		.chars_due   (chars_due)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("base64_stream_encoder regression: fail");
			$finish;
		end
	end

	// one byte request, returns at the edge that takes it
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin, input logic burst);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= fin;
		do @(posedge clk); while (byte_stall);
	endtask

	initial begin : byte_source
		int unsigned bytes_sent;
		int unsigned msg_len;
		logic        burst;
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		data_byte  <= '0;
		last_byte  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte messages, both extremes
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b1, 1'b0);
		// two byte message
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
		// full group closing the message
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		// plus and slash characters
		send_byte(8'hfb, 1'b0, 1'b1);
		send_byte(8'hef, 1'b0, 1'b1);
		send_byte(8'hbe, 1'b0, 1'b1);
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'hff, 1'b1, 1'b1);
		// full group then one byte
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h02, 1'b0, 1'b0);
		send_byte(8'h03, 1'b0, 1'b0);
		send_byte(8'h04, 1'b1, 1'b0);
		// full group then two bytes
		send_byte(8'h10, 1'b0, 1'b1);
		send_byte(8'h20, 1'b0, 1'b1);
		send_byte(8'h30, 1'b0, 1'b1);
		send_byte(8'h40, 1'b0, 1'b1);
		send_byte(8'h50, 1'b1, 1'b1);

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			burst = ($urandom_range(0, 2) == 0);
			for (int i = 1; i <= msg_len; i++) begin
				send_byte(8'($urandom_range(0, 255)), i == msg_len, burst);
			end
			bytes_sent += msg_len;
		end
		byte_valid <= 1'b0;

		@(posedge clk);
		while (chars_due != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("base64_stream_encoder regression: pass");
		end else begin
			$display("base64_stream_encoder regression: fail");
		end
		$finish;
	end

	// character side, with one long hold-off to back the encoder up
	initial begin : char_sink
		int unsigned hold;
		logic        calm;
		chars_taken = 0;
		calm = 1'b0;
		forever begin
			if (chars_taken % 20 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
			hold = calm ? 0 : $urandom_range(0, 9);
			if (chars_taken == HOLD_AT_CHAR) begin
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				char_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			char_stall <= 1'b0;
			do @(posedge clk); while (!char_valid);
			chars_taken++;
		end
	end

endmodule
